FILE: hw/rtl/rhh_pkg.sv
// Shared types, codes and constants for the Robin Hood hash table.
`default_nettype none
package rhh_pkg;

   localparam int SLOTS_DEF = 1024;
   localparam int CNT_W = 11;
   localparam int DATA_W = 64;

   localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd768;

   // splitmix64 finalizer multipliers
   localparam logic [DATA_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [DATA_W-1:0] MIX_C2 = 64'h94d049bb133111eb;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_CLEAR  = 2'd3
   } rhh_action_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4,
      ST_REMOVED   = 3'd5,
      ST_CLEARED   = 3'd6
   } rhh_status_type;

   typedef struct packed {
      rhh_action_type     action;
      logic [DATA_W-1:0]  key;
      logic [DATA_W-1:0]  value;
   } rhh_cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } rhh_front_state_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_RD,
      B_EV,
      B_CLR,
      B_OUT
   } rhh_back_state_type;

   typedef enum logic [1:0] {
      PH_LOCATE,
      PH_PLACE,
      PH_SHIFT
   } rhh_phase_type;

endpackage
`default_nettype wire

FILE: hw/rtl/rhh_front.sv
// Front end: takes a request, hashes its key with a shared 32x32 multiplier, queues it.
`default_nettype none
module rhh_front #(
   parameter int IW = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rhh_pkg::rhh_cmd_type req_cmd,
   input  logic                 init_busy,
   input  logic                 q_full,
   output logic                 q_push,
   output rhh_pkg::rhh_cmd_type q_cmd,
   output logic [IW-1:0]        q_home
);
   import rhh_pkg::*;

   rhh_front_state_type st_ff, st_in;
   rhh_cmd_type         cmd_ff, cmd_in;
   logic [63:0]         a_ff, a_in;
   logic [63:0]         acc_ff, acc_in;
   logic [63:0]         pr_ff, pr_in;
   logic [1:0]          step_ff, step_in;
   logic                round_ff, round_in;
   logic [IW-1:0]       home_ff, home_in;

   logic [63:0] mul_c;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic [63:0] prod;
   logic [63:0] hash;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // request and hash datapath
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      a_ff     <= a_in;
      acc_ff   <= acc_in;
      pr_ff    <= pr_in;
      step_ff  <= step_in;
      round_ff <= round_in;
      home_ff  <= home_in;
   end

   assign q_cmd  = cmd_ff;
   assign q_home = home_ff;

   // 64x64 low product from three 32x32 partials, one per cycle, product registered
   always_comb begin
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      pr_in    = pr_ff;
      step_in  = step_ff;
      round_in = round_ff;
      home_in  = home_ff;
      q_push   = 1'b0;
      prod     = '0;
      hash     = '0;
      mul_c    = round_ff ? MIX_C2 : MIX_C1;
      req_stall = (st_ff != F_IDLE) || init_busy;

      case (step_ff)
         2'd0: begin
            mul_x = a_ff[31:0];
            mul_y = mul_c[31:0];
         end
         2'd1: begin
            mul_x = a_ff[31:0];
            mul_y = mul_c[63:32];
         end
         2'd2: begin
            mul_x = a_ff[63:32];
            mul_y = mul_c[31:0];
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      mul_p = 64'(mul_x) * 64'(mul_y);

      case (st_ff)
         F_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd_in   = req_cmd;
               a_in     = req_cmd.key ^ (req_cmd.key >> 30);
               step_in  = 2'd0;
               round_in = 1'b0;
               st_in    = F_MUL;
            end
         end
         F_MUL: begin
            pr_in   = mul_p;
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0:    acc_in = '0;
               2'd1:    acc_in = acc_ff + pr_ff;
               default: acc_in = acc_ff + {pr_ff[31:0], 32'h0};
            endcase
            if (step_ff == 2'd3) begin
               prod = acc_in;
               if (!round_ff) begin
                  a_in     = prod ^ (prod >> 27);
                  round_in = 1'b1;
               end else begin
                  hash    = prod ^ (prod >> 31);
                  home_in = hash[IW-1:0];
                  st_in   = F_PUSH;
               end
            end
         end
         F_PUSH: begin
            q_push = !q_full;
            if (!q_full) begin
               st_in = F_IDLE;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/rhh_queue.sv
// Two-entry queue between the hashing front end and the table engine.
`default_nettype none
module rhh_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output logic [W-1:0] head
);

   localparam int DEPTH = 2;
   localparam int PW = $clog2(DEPTH);

   logic [W-1:0]  slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff;

   assign full      = (cnt_ff == (PW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/rhh_back.sv
// Table engine: slot memory, probe walks, Robin Hood insert, backward-shift remove, clear.
`default_nettype none
module rhh_back #(
   parameter int SLOTS = rhh_pkg::SLOTS_DEF,
   parameter int IW = $clog2(SLOTS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  rhh_pkg::rhh_cmd_type         q_cmd,
   input  logic [IW-1:0]                q_home,
   output logic                         q_pop,
   input  logic [rhh_pkg::CNT_W-1:0]    max_entries,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output rhh_pkg::rhh_status_type      rsp_status,
   output logic [rhh_pkg::DATA_W-1:0]   rsp_value,
   output logic [rhh_pkg::CNT_W-1:0]    rsp_count,
   output logic                         init_busy
);
   import rhh_pkg::*;

   localparam int CW = IW + 1;
   localparam int KW = (CW > CNT_W) ? CW : CNT_W;
   localparam logic [IW-1:0] LAST_POS = IW'(SLOTS - 1);
   localparam logic [IW:0]   LAST_N   = (IW+1)'(SLOTS - 1);
   localparam logic [IW:0]   ALL_N    = (IW+1)'(SLOTS);
   localparam logic [CW-1:0] OCC_MAX  = CW'(SLOTS);

   typedef struct packed {
      logic          valid;
      logic [IW-1:0] pdist;
      logic [63:0]   key;
      logic [63:0]   value;
   } ent_type;

   ent_type mem [SLOTS];
   ent_type rd_ff;

   logic    mem_we, mem_re;
   logic [IW-1:0] mem_wa, mem_ra;
   ent_type mem_wd;

   rhh_back_state_type st_ff, st_in;
   rhh_phase_type      ph_ff, ph_in;
   rhh_action_type     act_ff, act_in;
   rhh_status_type     res_ff, res_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [IW-1:0]      dist_ff, dist_in;
   logic [IW:0]        n_ff, n_in;
   logic [63:0]        k_ff, k_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        vout_ff, vout_in;
   logic [CW-1:0]      occ_ff, occ_in;

   logic               ov_ff, ov_in;
   rhh_status_type     ost_ff, ost_in;
   logic [63:0]        oval_ff, oval_in;
   logic [CNT_W-1:0]   ocnt_ff, ocnt_in;

   logic [IW-1:0] pos_nx;
   logic          miss, hit, full;

   assign rsp_valid  = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_value  = oval_ff;
   assign rsp_count  = ocnt_ff;
   assign init_busy  = (st_ff == B_INIT);

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_INIT;
         pos_ff <= '0;
         occ_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
         occ_ff <= occ_in;
         ov_ff  <= ov_in;
      end
   end

   // operation payload
   always_ff @(posedge clock) begin
      ph_ff   <= ph_in;
      act_ff  <= act_in;
      res_ff  <= res_in;
      dist_ff <= dist_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      v_ff    <= v_in;
      vout_ff <= vout_in;
      ost_ff  <= ost_in;
      oval_ff <= oval_in;
      ocnt_ff <= ocnt_in;
   end

   // sequencer
   always_comb begin
      st_in   = st_ff;
      ph_in   = ph_ff;
      act_in  = act_ff;
      res_in  = res_ff;
      pos_in  = pos_ff;
      dist_in = dist_ff;
      n_in    = n_ff;
      k_in    = k_ff;
      v_in    = v_ff;
      vout_in = vout_ff;
      occ_in  = occ_ff;
      ov_in   = ov_ff && rsp_stall;
      ost_in  = ost_ff;
      oval_in = oval_ff;
      ocnt_in = ocnt_ff;
      q_pop   = 1'b0;
      mem_we  = 1'b0;
      mem_wa  = pos_ff;
      mem_wd  = '0;
      mem_re  = 1'b0;
      mem_ra  = pos_ff;

      pos_nx = pos_ff + 1'b1;
      miss   = !rd_ff.valid || (dist_ff > rd_ff.pdist);
      hit    = !miss && (rd_ff.key == k_ff);
      full   = (KW'(occ_ff) >= KW'(max_entries)) || (occ_ff >= OCC_MAX);

      case (st_ff)
         // sweep after reset marks every slot empty
         B_INIT: begin
            mem_we = 1'b1;
            pos_in = pos_nx;
            if (pos_ff == LAST_POS) begin
               st_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               act_in  = q_cmd.action;
               k_in    = q_cmd.key;
               v_in    = q_cmd.value;
               pos_in  = q_home;
               dist_in = '0;
               n_in    = '0;
               vout_in = '0;
               ph_in   = PH_LOCATE;
               if (q_cmd.action == ACT_CLEAR) begin
                  pos_in = '0;
                  st_in  = B_CLR;
               end else begin
                  st_in = B_RD;
               end
            end
         end
         B_CLR: begin
            mem_we = 1'b1;
            pos_in = pos_nx;
            if (pos_ff == LAST_POS) begin
               occ_in = '0;
               res_in = ST_CLEARED;
               st_in  = B_OUT;
            end
         end
         B_RD: begin
            if ((ph_ff == PH_SHIFT) && (n_ff == ALL_N)) begin
               mem_we = 1'b1;
               occ_in = occ_ff - 1'b1;
               res_in = ST_REMOVED;
               st_in  = B_OUT;
            end else begin
               mem_re = 1'b1;
               mem_ra = (ph_ff == PH_SHIFT) ? pos_nx : pos_ff;
               st_in  = B_EV;
            end
         end
         B_EV: begin
            st_in = B_RD;
            case (ph_ff)
               PH_LOCATE: begin
                  if (hit) begin
                     case (act_ff)
                        ACT_INSERT: begin
                           mem_we       = 1'b1;
                           mem_wd       = rd_ff;
                           mem_wd.value = v_ff;
                           res_in       = ST_UPDATED;
                           st_in        = B_OUT;
                        end
                        ACT_LOOKUP: begin
                           vout_in = rd_ff.value;
                           res_in  = ST_FOUND;
                           st_in   = B_OUT;
                        end
                        default: begin
                           vout_in = rd_ff.value;
                           n_in    = '0;
                           ph_in   = PH_SHIFT;
                        end
                     endcase
                  end else if (miss || (n_ff == LAST_N)) begin
                     if (act_ff == ACT_INSERT) begin
                        // a new key picks up where the search stopped
                        if (full) begin
                           res_in = ST_FULL;
                           st_in  = B_OUT;
                        end else begin
                           ph_in = PH_PLACE;
                        end
                     end else begin
                        res_in = ST_NOT_FOUND;
                        st_in  = B_OUT;
                     end
                  end else begin
                     dist_in = dist_ff + 1'b1;
                     pos_in  = pos_nx;
                     n_in    = n_ff + 1'b1;
                  end
               end
               PH_PLACE: begin
                  if (!rd_ff.valid) begin
                     mem_we = 1'b1;
                     mem_wd = '{valid: 1'b1, pdist: dist_ff, key: k_ff, value: v_ff};
                     occ_in = occ_ff + 1'b1;
                     res_in = ST_INSERTED;
                     st_in  = B_OUT;
                  end else if (rd_ff.pdist < dist_ff) begin
                     // richer resident gives up its slot and moves on
                     mem_we  = 1'b1;
                     mem_wd  = '{valid: 1'b1, pdist: dist_ff, key: k_ff, value: v_ff};
                     k_in    = rd_ff.key;
                     v_in    = rd_ff.value;
                     dist_in = rd_ff.pdist + 1'b1;
                     pos_in  = pos_nx;
                  end else begin
                     dist_in = dist_ff + 1'b1;
                     pos_in  = pos_nx;
                  end
               end
               default: begin
                  // backward shift: pull the next entry one slot closer to home
                  if (!rd_ff.valid || (rd_ff.pdist == '0)) begin
                     mem_we = 1'b1;
                     occ_in = occ_ff - 1'b1;
                     res_in = ST_REMOVED;
                     st_in  = B_OUT;
                  end else begin
                     mem_we       = 1'b1;
                     mem_wd       = rd_ff;
                     mem_wd.pdist = rd_ff.pdist - 1'b1;
                     pos_in       = pos_nx;
                     n_in         = n_ff + 1'b1;
                  end
               end
            endcase
         end
         B_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in   = 1'b1;
               ost_in  = res_ff;
               oval_in = vout_ff;
               ocnt_in = CNT_W'(occ_ff);
               st_in   = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: ports, limit register, front end, queue, engine.
`default_nettype none
// Open-addressing table of 64-bit keys and values with Robin Hood insertion and
// backward-shift removal; one response per request. After reset the slot memory is
// swept while req_stall stays high; clear runs the same sweep. The front end hashes
// each key with one shared 32x32 multiplier and hands it to a two-entry queue, so
// hashing overlaps the previous table operation. The front end takes no new request
// until the last one is through its steps (accept, multiply steps, push), and waits
// longer when the queue is full; that sets the request rate whenever the engine is
// faster. The engine reads its slot memory with registered read data: each probed
// slot goes through a read state and an evaluate state, insert of a new key walks on
// slot by slot to an empty one, and remove shifts entries back one by one.
// csr_ready is always high; write the limit only while idle.
module robin_hood_hash_table #(
   parameter int SLOTS = rhh_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic signed [63:0]          req_key,
   input  logic signed [63:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic signed [63:0]          rsp_value_out,
   output logic [rhh_pkg::CNT_W-1:0]   rsp_entry_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rhh_pkg::CNT_W-1:0]   csr_data
);
   import rhh_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int QW = $bits(rhh_cmd_type) + IW;

   logic [CNT_W-1:0] max_ff;
   rhh_cmd_type      req_cmd, f_cmd, b_cmd;
   logic [IW-1:0]    f_home, b_home;
   logic             q_push, q_full, q_pop, q_valid, init_busy;
   logic [QW-1:0]    q_head;
   rhh_status_type   b_status;

   // occupancy limit register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ENTRIES_RST;
      end else if (csr_valid && csr_ready) begin
         max_ff <= csr_data;
      end
   end

   assign req_cmd.action = rhh_action_type'(req_action);
   assign req_cmd.key    = req_key;
   assign req_cmd.value  = req_value;

   rhh_front #(.IW(IW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (f_cmd),
      .q_home    (f_home)
   );

   rhh_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_home, f_cmd}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   assign {b_home, b_cmd} = q_head;

   rhh_back #(.SLOTS(SLOTS), .IW(IW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (b_cmd),
      .q_home      (b_home),
      .q_pop       (q_pop),
      .max_entries (max_ff),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_status  (b_status),
      .rsp_value   (rsp_value_out),
      .rsp_count   (rsp_entry_count),
      .init_busy   (init_busy)
   );

   assign rsp_status = b_status;

   // checks
   a_init_blocks_req: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> req_stall)
      else $error("request accepted during slot sweep");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (b_status == ST_CLEARED)) |-> (rsp_entry_count == '0))
      else $error("clear response with nonzero count");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (b_status != ST_FOUND) && (b_status != ST_REMOVED))
         |-> (rsp_value_out == '0))
      else $error("value on response without a found entry");

endmodule
`default_nettype wire
